// File: rtl/sbfp_pkg.sv
// ----------------------------------------------------------------------------
// sbfp_pkg
// Shared constants and types of the seven-bit field packer.
// ----------------------------------------------------------------------------
package sbfp_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int MAX_FIELD_BITS  = 32;

    localparam int VALUE_W   = 32;
    localparam int WIDTH_W   = 6;
    localparam int IN_DATA_W = 40;
    localparam int ID_W      = 6;
    localparam int SUM_W     = 21;
    localparam int ACC_W     = VALUE_W + 7;

    localparam logic [6:0] DATA_CAP  = 7'(MAX_FRAME_BYTES - 5);
    localparam logic [7:0] HDR_MARK  = 8'h80;
    localparam logic [5:0] BYTE_BITS = 6'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value_al;
        logic [WIDTH_W-1:0] width;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_byte;

endpackage

// File: rtl/seven_bit_field_packer.sv
// ----------------------------------------------------------------------------
// seven_bit_field_packer
// Packs variable-width fields into framed 7-bit data bytes with checksum.
// ----------------------------------------------------------------------------
// Slave stream: one field per item, field_value and field_width in tdata,
// tlast closes the frame. Master stream: one frame byte per item, tlast on
// the trailer byte, tuser carries the overflow flag on the trailer.
// The config port writes device_id for the header byte; write while idle.
// Each item waits in the input register and is loaded by the sequencer,
// which then emits one byte per cycle while the receiver does not stall: an
// optional header, up to five data bytes, and on the last field an optional
// pad, three checksum bytes and trailer. The first byte passes through the
// input register, a sequencer load step and the output register before it
// is valid on the master side. The next item is accepted into the
// input register while the current one is still being sent.
// Reset (synchronous, active low) closes any open frame and clears
// device_id. A stalled receiver holds the output register and freezes the
// sequencer; the input side stalls once its register is full.
// ----------------------------------------------------------------------------
module seven_bit_field_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [sbfp_pkg::ID_W-1:0]      i_cfg_wr_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [31:0] field_value, [37:32] field_width, [39:38] zero
    input  logic [sbfp_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] out_byte
    output logic [7:0]                     o_m_tdata,
    output logic                           o_m_tlast,
    // [0] overflow
    output logic                           o_m_tuser
);

    logic            w_in_valid;
    sbfp_pkg::t_item w_item;
    logic            w_take;
    logic            w_adv;
    logic            w_emit;
    sbfp_pkg::t_byte w_byte;

    sbfp_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .i_take   (w_take),
        .o_valid  (w_in_valid),
        .o_item   (w_item)
    );

    sbfp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (w_in_valid),
        .i_item        (w_item),
        .o_take        (w_take),
        .i_adv         (w_adv),
        .o_emit        (w_emit),
        .o_byte        (w_byte)
    );

    sbfp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (w_emit),
        .i_byte   (w_byte),
        .o_adv    (w_adv),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast),
        .o_tuser  (o_m_tuser)
    );

endmodule

// File: rtl/sbfp_in_stage.sv
// ----------------------------------------------------------------------------
// sbfp_in_stage
// Input register: holds one item, saturates its width and left-aligns its bits.
// ----------------------------------------------------------------------------
module sbfp_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    // [31:0] field_value, [37:32] field_width, [39:38] zero
    input  logic [sbfp_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic                          i_tlast,
    input  logic                          i_take,
    output logic                          o_valid,
    output sbfp_pkg::t_item               o_item
);

    logic                           r_valid;
    sbfp_pkg::t_item                r_item;
    logic [sbfp_pkg::WIDTH_W-1:0]   w_raw;
    logic [sbfp_pkg::WIDTH_W-1:0]   w_sat;
    logic [sbfp_pkg::WIDTH_W-1:0]   w_shift;
    logic                           w_accept;

    assign w_raw   = i_tdata[sbfp_pkg::VALUE_W +: sbfp_pkg::WIDTH_W];
    assign w_sat   = (w_raw > sbfp_pkg::WIDTH_W'(sbfp_pkg::MAX_FIELD_BITS)) ?
                     sbfp_pkg::WIDTH_W'(sbfp_pkg::MAX_FIELD_BITS) : w_raw;
    assign w_shift = sbfp_pkg::WIDTH_W'(sbfp_pkg::VALUE_W) - w_sat;

    assign o_tready = !r_valid || i_take;
    assign w_accept = i_tvalid && o_tready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.value_al <= i_tdata[sbfp_pkg::VALUE_W-1:0] << w_shift;
            r_item.width    <= w_sat;
            r_item.last     <= i_tlast;
        end
    end

endmodule

// File: rtl/sbfp_core.sv
// ----------------------------------------------------------------------------
// sbfp_core
// Frame sequencer: header, 7-bit data bytes, pad, checksum and trailer.
// ----------------------------------------------------------------------------
module sbfp_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [sbfp_pkg::ID_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    input  sbfp_pkg::t_item           i_item,
    output logic                      o_take,
    input  logic                      i_adv,
    output logic                      o_emit,
    output sbfp_pkg::t_byte           o_byte
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_PAD  = 3'd3;
    localparam logic [2:0] PH_CK2  = 3'd4;
    localparam logic [2:0] PH_CK1  = 3'd5;
    localparam logic [2:0] PH_CK0  = 3'd6;
    localparam logic [2:0] PH_TRL  = 3'd7;

    localparam int AW = sbfp_pkg::ACC_W;

    logic [2:0]                  r_phase, n_phase;
    logic [AW-1:0]               r_acc, n_acc;
    logic [5:0]                  r_cnt, n_cnt;
    logic                        r_last, n_last;
    logic [6:0]                  r_pend, n_pend;
    logic [2:0]                  r_filled, n_filled;
    logic [6:0]                  r_fb, n_fb;
    logic [sbfp_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic                        r_in_frame, n_in_frame;
    logic                        r_dropped, n_dropped;
    logic [sbfp_pkg::ID_W-1:0]   r_dev_id;

    logic [AW-1:0]  acc_ld, acc_sh, dec_acc;
    logic [5:0]     cnt_ld, cnt_sh, dec_cnt;
    logic [6:0]     dec_d;
    logic           dec_last, dec_room, dec_emit;
    logic [6:0]     fin_pend;
    logic [2:0]     fin_filled;
    logic           fin_drop;
    logic [2:0]     dec_phase;

    assign acc_ld = {r_pend, sbfp_pkg::VALUE_W'(0)} |
                    ({i_item.value_al, 7'd0} >> r_filled);
    assign cnt_ld = {3'd0, r_filled} + i_item.width;
    assign acc_sh = r_acc << 7;
    assign cnt_sh = r_cnt - sbfp_pkg::BYTE_BITS;

    always_comb begin
        unique case (r_phase)
            PH_IDLE: begin
                dec_acc  = acc_ld;
                dec_cnt  = cnt_ld;
                dec_d    = r_fb - 7'd1;
                dec_last = i_item.last;
            end
            PH_HDR: begin
                dec_acc  = r_acc;
                dec_cnt  = r_cnt;
                dec_d    = 7'd0;
                dec_last = r_last;
            end
            default: begin
                dec_acc  = acc_sh;
                dec_cnt  = cnt_sh;
                dec_d    = r_fb;
                dec_last = r_last;
            end
        endcase
        dec_room   = dec_d < sbfp_pkg::DATA_CAP;
        dec_emit   = (dec_cnt >= sbfp_pkg::BYTE_BITS) && dec_room;
        fin_pend   = dec_room ? dec_acc[AW-1 -: 7] : 7'd0;
        fin_filled = dec_room ? dec_cnt[2:0] : 3'd0;
        fin_drop   = !dec_room && (dec_cnt != 6'd0);
        if (dec_emit) begin
            dec_phase = PH_DATA;
        end else if (dec_last) begin
            dec_phase = (fin_filled != 3'd0) ? PH_PAD : PH_CK2;
        end else begin
            dec_phase = PH_IDLE;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_pend     = r_pend;
        n_filled   = r_filled;
        n_fb       = r_fb;
        n_sum      = r_sum;
        n_in_frame = r_in_frame;
        n_dropped  = r_dropped;
        o_take     = 1'b0;
        o_emit     = 1'b0;
        o_byte     = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_in_valid) begin
                    o_take = 1'b1;
                    n_acc  = acc_ld;
                    n_cnt  = cnt_ld;
                    n_last = i_item.last;
                    if (!r_in_frame) begin
                        n_phase = PH_HDR;
                    end else begin
                        n_phase = dec_phase;
                        if (!dec_emit) begin
                            n_pend    = fin_pend;
                            n_filled  = fin_filled;
                            n_dropped = r_dropped | fin_drop;
                        end
                    end
                end
            end
            PH_HDR: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = sbfp_pkg::HDR_MARK | {2'd0, r_dev_id};
                    n_fb        = 7'd1;
                    n_in_frame  = 1'b1;
                    n_phase     = dec_phase;
                    if (!dec_emit) begin
                        n_pend    = fin_pend;
                        n_filled  = fin_filled;
                        n_dropped = r_dropped | fin_drop;
                    end
                end
            end
            PH_DATA: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = {1'b0, r_acc[AW-1 -: 7]};
                    n_sum       = r_sum + sbfp_pkg::SUM_W'(r_acc[AW-1 -: 7]);
                    n_fb        = r_fb + 7'd1;
                    n_acc       = acc_sh;
                    n_cnt       = cnt_sh;
                    n_phase     = dec_phase;
                    if (!dec_emit) begin
                        n_pend    = fin_pend;
                        n_filled  = fin_filled;
                        n_dropped = r_dropped | fin_drop;
                    end
                end
            end
            PH_PAD: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = {1'b0, r_pend};
                    n_sum       = r_sum + sbfp_pkg::SUM_W'(r_pend);
                    n_fb        = r_fb + 7'd1;
                    n_pend      = 7'd0;
                    n_filled    = 3'd0;
                    n_phase     = PH_CK2;
                end
            end
            PH_CK2: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = {1'b0, r_sum[20:14]};
                    n_fb        = r_fb + 7'd1;
                    n_phase     = PH_CK1;
                end
            end
            PH_CK1: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = {1'b0, r_sum[13:7]};
                    n_fb        = r_fb + 7'd1;
                    n_phase     = PH_CK0;
                end
            end
            PH_CK0: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = {1'b0, r_sum[6:0]};
                    n_fb        = r_fb + 7'd1;
                    n_phase     = PH_TRL;
                end
            end
            PH_TRL: begin
                if (i_adv) begin
                    o_emit      = 1'b1;
                    o_byte.data = sbfp_pkg::HDR_MARK | {1'b0, 7'(r_fb + 7'd1)};
                    o_byte.last = 1'b1;
                    o_byte.ovf  = r_dropped;
                    n_pend      = 7'd0;
                    n_filled    = 3'd0;
                    n_fb        = 7'd0;
                    n_sum       = '0;
                    n_in_frame  = 1'b0;
                    n_dropped   = 1'b0;
                    n_phase     = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pend     <= 7'd0;
            r_filled   <= 3'd0;
            r_fb       <= 7'd0;
            r_sum      <= '0;
            r_in_frame <= 1'b0;
            r_dropped  <= 1'b0;
            r_dev_id   <= '0;
            r_cnt      <= 6'd0;
            r_last     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pend     <= n_pend;
            r_filled   <= n_filled;
            r_fb       <= n_fb;
            r_sum      <= n_sum;
            r_in_frame <= n_in_frame;
            r_dropped  <= n_dropped;
            r_cnt      <= n_cnt;
            r_last     <= n_last;
            if (i_cfg_wr_en) begin
                r_dev_id <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    a_emit_needs_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_adv)
        else $error("byte emitted while output stage is full");

    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled != 3'd7)
        else $error("pending bit count reached a full byte");

    a_closed_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_fb == 7'd0 && r_sum == '0 && !r_dropped))
        else $error("frame state left over outside a frame");

    a_trailer_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_byte.last) |=> (!r_in_frame && r_phase == PH_IDLE))
        else $error("frame still open after trailer");

    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_phase == PH_IDLE && i_in_valid))
        else $error("item taken while sequencer busy");

endmodule

// File: rtl/sbfp_out_stage.sv
// ----------------------------------------------------------------------------
// sbfp_out_stage
// Output register: holds one frame byte until the receiver takes it.
// ----------------------------------------------------------------------------
module sbfp_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_emit,
    input  sbfp_pkg::t_byte i_byte,
    output logic            o_adv,
    output logic            o_tvalid,
    input  logic            i_tready,
    // [7:0] out_byte
    output logic [7:0]      o_tdata,
    output logic            o_tlast,
    // [0] overflow
    output logic            o_tuser
);

    logic            r_valid;
    sbfp_pkg::t_byte r_byte;

    assign o_adv    = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_byte.data;
    assign o_tlast  = r_byte.last;
    assign o_tuser  = r_byte.ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_emit) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: tb/sv/tb_seven_bit_field_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_bit_field_packer
// Self-checking testbench for the seven-bit field packer. A driver feeds
// fields from a queue and a monitor checks every frame byte against a
// behavioral packer that tracks header, data, checksum, trailer and overflow.
// Each phase sets a device id; all but the calm one stall both streams at random.
// ----------------------------------------------------------------------------
module tb_seven_bit_field_packer;

    localparam int CLK_PERIOD = 20;
    localparam int RUN_LIMIT  = 200000;
    localparam int DRAIN_WAIT = 20;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [sbfp_pkg::VALUE_W-1:0] value;
        logic [sbfp_pkg::WIDTH_W-1:0] width;
        logic                         last;
    } t_field;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [sbfp_pkg::ID_W-1:0]      i_cfg_wr_data = '0;
    logic                           i_s_tvalid    = 1'b0;
    logic                           o_s_tready;
    // [31:0] field_value, [37:32] field_width, [39:38] zero
    logic [sbfp_pkg::IN_DATA_W-1:0] i_s_tdata     = '0;
    logic                           i_s_tlast     = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready    = 1'b0;
    // [7:0] out_byte
    logic [7:0]                     o_m_tdata;
    logic                           o_m_tlast;
    // [0] overflow
    logic                           o_m_tuser;

    seven_bit_field_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser)
    );

    t_field          field_q[$];
    sbfp_pkg::t_byte frame_byte_q[$];
    int              err_cnt   = 0;
    int              cycle_cnt = 0;
    bit              calm      = 1'b0;
    bit              hold_req  = 1'b0;
    bit              hold_done = 1'b0;
    int              hold_left = 0;
    bit              s_took    = 1'b0;

    // packer state
    logic [sbfp_pkg::ID_W-1:0]  dev_id    = '0;
    logic [6:0]                 acc_bits  = '0;
    int                         fill_cnt  = 0;
    logic [6:0]                 frame_cnt = '0;
    logic [sbfp_pkg::SUM_W-1:0] byte_sum  = '0;
    bit                         in_frame  = 1'b0;
    bit                         dropped   = 1'b0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic emit_byte(input logic [7:0] data, input logic last, input logic ovf);
        sbfp_pkg::t_byte b;
        b.data = data;
        b.last = last;
        b.ovf  = ovf;
        frame_byte_q.push_back(b);
        frame_cnt = frame_cnt + 7'd1;
    endtask

    task automatic emit_data(input logic [6:0] data);
        byte_sum = byte_sum + sbfp_pkg::SUM_W'(data);
        emit_byte({1'b0, data}, 1'b0, 1'b0);
    endtask

    task automatic pack_field(input logic [sbfp_pkg::VALUE_W-1:0] value,
                              input logic [sbfp_pkg::WIDTH_W-1:0] width_in,
                              input logic                         last);
        int w;
        w = (width_in > sbfp_pkg::MAX_FIELD_BITS) ? sbfp_pkg::MAX_FIELD_BITS
                                                  : int'(width_in);
        if (!in_frame) begin
            in_frame  = 1'b1;
            frame_cnt = '0;
            emit_byte(sbfp_pkg::HDR_MARK | {2'b00, dev_id}, 1'b0, 1'b0);
        end
        for (int k = 0; k < w; k++) begin
            if (int'(frame_cnt) - 1 >= int'(sbfp_pkg::DATA_CAP)) begin
                dropped = 1'b1;
            end else begin
                acc_bits = {acc_bits[5:0], value[w-1-k]};
                fill_cnt++;
                if (fill_cnt == 7) begin
                    emit_data(acc_bits);
                    acc_bits = '0;
                    fill_cnt = 0;
                end
            end
        end
        if (last) begin
            if (fill_cnt != 0) begin
                emit_data(7'(acc_bits << (7 - fill_cnt)));
            end
            emit_byte({1'b0, byte_sum[20:14]}, 1'b0, 1'b0);
            emit_byte({1'b0, byte_sum[13:7]}, 1'b0, 1'b0);
            emit_byte({1'b0, byte_sum[6:0]}, 1'b0, 1'b0);
            emit_byte(sbfp_pkg::HDR_MARK | {1'b0, 7'(frame_cnt + 7'd1)}, 1'b1, dropped);
            acc_bits  = '0;
            fill_cnt  = 0;
            frame_cnt = '0;
            byte_sum  = '0;
            in_frame  = 1'b0;
            dropped   = 1'b0;
        end
    endtask

    task automatic add_field(input logic [sbfp_pkg::VALUE_W-1:0] value,
                             input int width, input logic last);
        t_field f;
        f.value = value;
        f.width = sbfp_pkg::WIDTH_W'(width);
        f.last  = last;
        field_q.push_back(f);
    endtask

    // Mostly in-range widths, with some zero and oversize widths mixed in.
    task automatic add_frame(input int n_fields, input bit wide);
        int r;
        int w;
        for (int k = 0; k < n_fields; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) w = 0;
            else if (r < 10) w = $urandom_range(sbfp_pkg::MAX_FIELD_BITS + 1, 63);
            else if (wide) w = sbfp_pkg::MAX_FIELD_BITS;
            else w = $urandom_range(1, sbfp_pkg::MAX_FIELD_BITS);
            add_field($urandom, w, k == n_fields - 1);
        end
    endtask

    task automatic wait_idle();
        while (field_q.size() != 0 || i_s_tvalid || frame_byte_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_device_id(input logic [sbfp_pkg::ID_W-1:0] id);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        dev_id = id;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_field f;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_took) begin
            if (field_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                f = field_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {2'b00, f.width, f.value};
                i_s_tlast  <= f.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        sbfp_pkg::t_byte exp_b;
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        s_took = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (frame_byte_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte data=%02h last=%b ovf=%b",
                                          o_m_tdata, o_m_tlast, o_m_tuser));
            end else begin
                exp_b = frame_byte_q.pop_front();
                if ({o_m_tdata, o_m_tlast, o_m_tuser} !== {exp_b.data, exp_b.last, exp_b.ovf})
                    report_mismatch($sformatf(
                        "byte data=%02h last=%b ovf=%b, expected %02h %b %b",
                        o_m_tdata, o_m_tlast, o_m_tuser, exp_b.data, exp_b.last, exp_b.ovf));
            end
        end
        if (s_took)
            pack_field(i_s_tdata[sbfp_pkg::VALUE_W-1:0],
                       i_s_tdata[sbfp_pkg::VALUE_W+sbfp_pkg::WIDTH_W-1:sbfp_pkg::VALUE_W],
                       i_s_tlast);
    end

    initial begin
        logic [sbfp_pkg::ID_W-1:0] phase_id[4];
        int added;
        int n;
        bit wide;
        phase_id[0] = 6'd63;
        phase_id[1] = sbfp_pkg::ID_W'($urandom);
        phase_id[2] = 6'd0;
        phase_id[3] = 6'd21;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        write_device_id(6'd0);
        add_field(32'h0000_0001, 1, 1'b1);
        add_field(32'hFFFF_FFFF, 32, 1'b0);
        add_field(32'h0000_0000, 32, 1'b1);
        add_field(32'hFFFF_FFFF, 0, 1'b0);
        add_field(32'hFFFF_FFFF, 0, 1'b1);
        add_field(32'hA5A5_A5A5, 63, 1'b0);
        add_field(32'h5A5A_5A5A, 33, 1'b0);
        add_field(32'h0000_007F, 7, 1'b1);
        add_field(32'h0000_0055, 7, 1'b1);
        for (int k = 0; k < 14; k++)
            add_field(32'hFFFF_FFFF ^ k, 32, k == 13);
        wait_idle();

        // random phases
        for (int p = 0; p < 4; p++) begin
            write_device_id(phase_id[p]);
            calm = (p == 1);
            if (p == 1) hold_req = 1'b1;
            added = 0;
            while (added < 36) begin
                wide = ($urandom_range(0, 9) == 0);
                n = wide ? $urandom_range(13, 18) : $urandom_range(1, 6);
                add_frame(n, wide);
                added += n;
            end
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
